### rtl/imb_pkg.sv
`timescale 1ns / 1ps

package imb_pkg;

    // Geometry of the map.
    localparam int DIRECT_COUNT_DEF = 12;
    localparam int SECTOR_BYTES     = 512;
    localparam int SB_SHIFT         = $clog2(SECTOR_BYTES);
    localparam int OFFSET_W         = 31;
    localparam int BLK_W            = OFFSET_W - SB_SHIFT;
    localparam int EPI              = 128;
    localparam int EPI_W            = $clog2(EPI);
    localparam int LEAF_W           = 2 * EPI_W;
    localparam int LEAF_COUNT       = EPI * EPI;
    localparam int SECTOR_W         = 32;
    localparam int QDEPTH           = 2;

    localparam logic [SECTOR_W-1:0] NP = '1;

    // Request types.
    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_ABSENT  = 2'd1;
    localparam logic [1:0] STAT_BEYOND  = 2'd2;
    localparam logic [1:0] STAT_NOSPARE = 2'd3;

    // Classes of work handed from the front to the back.
    localparam logic [2:0] K_NOP    = 3'd0;
    localparam logic [2:0] K_CLEAR  = 3'd1;
    localparam logic [2:0] K_BEYOND = 3'd2;
    localparam logic [2:0] K_DIRECT = 3'd3;
    localparam logic [2:0] K_SINGLE = 3'd4;
    localparam logic [2:0] K_DOUBLE = 3'd5;

    typedef struct packed {
        logic [2:0]          kind;
        logic                ins;
        logic [LEAF_W-1:0]   idx;
        logic [SECTOR_W-1:0] data;
        logic                spare0_ok;
        logic                spare1_ok;
        logic [SECTOR_W-1:0] spare_first;
        logic [SECTOR_W-1:0] spare_second;
    } cmd_t;

endpackage

### rtl/inode_block_map_translate.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Fields
// request   in         in_valid / in_ready    req_type, byte_offset, data_sector,
//                                             spare_count, spare_first, spare_second
// result    out        out_valid / out_ready  sector, status, spares_used
//
// One result word per request word; an accepted word is registered in the queue first.
// The back end finishes a clear, a direct entry, a beyond-maximum offset, a single-indirect
// insert or an absent top-table slot straight from idle, waits on the single-table read for
// a single-indirect lookup, and on the double-indirect tree is paced by the chained top and
// leaf memory reads. Reset leaves the top table all absent at once. The back end waits while the result
// register is unread, and the two-word queue keeps accepting requests until it fills.

module inode_block_map_translate
    import imb_pkg::*;
#(
    parameter int DIRECT_COUNT = DIRECT_COUNT_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          req_type,
    input  logic [OFFSET_W-1:0] byte_offset,
    input  logic [SECTOR_W-1:0] data_sector,
    input  logic [1:0]          spare_count,
    input  logic [SECTOR_W-1:0] spare_first,
    input  logic [SECTOR_W-1:0] spare_second,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SECTOR_W-1:0] sector,
    output logic [1:0]          status,
    output logic [1:0]          spares_used
);

    logic q_full;
    logic push;
    cmd_t push_cmd;
    logic pop;
    logic q_valid;
    cmd_t head;

    imb_front #(
        .DIRECT_COUNT (DIRECT_COUNT)
    ) u_front (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .byte_offset  (byte_offset),
        .data_sector  (data_sector),
        .spare_count  (spare_count),
        .spare_first  (spare_first),
        .spare_second (spare_second),
        .q_full       (q_full),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    imb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_valid),
        .head      (head)
    );

    imb_back #(
        .DIRECT_COUNT (DIRECT_COUNT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sector      (sector),
        .status      (status),
        .spares_used (spares_used)
    );

`ifndef SYNTHESIS
    a_beyond_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_BEYOND) |-> (sector == NP) && (spares_used == 2'd0))
        else $error("beyond-maximum result carries a sector or used spares");

    a_nospare_np: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_NOSPARE) |-> (sector == NP) && (spares_used != 2'd2))
        else $error("failed insert reports a sector or both spares used");

    a_two_spares_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (spares_used == 2'd2) |-> (status == STAT_OK))
        else $error("two spares used without a successful insert");
`endif

endmodule

### rtl/imb_front.sv
`timescale 1ns / 1ps

module imb_front
    import imb_pkg::*;
#(
    parameter int DIRECT_COUNT = DIRECT_COUNT_DEF
)
(
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          req_type,
    input  logic [OFFSET_W-1:0] byte_offset,
    input  logic [SECTOR_W-1:0] data_sector,
    input  logic [1:0]          spare_count,
    input  logic [SECTOR_W-1:0] spare_first,
    input  logic [SECTOR_W-1:0] spare_second,
    input  logic                q_full,
    output logic                push,
    output cmd_t                push_cmd
);

    localparam logic [BLK_W-1:0] DIRECT_END = BLK_W'(DIRECT_COUNT);
    localparam logic [BLK_W-1:0] SINGLE_END = BLK_W'(DIRECT_COUNT + EPI);
    localparam logic [BLK_W-1:0] BLOCK_MAX  = BLK_W'(DIRECT_COUNT + EPI + LEAF_COUNT);

    logic [BLK_W-1:0] block;
    logic [BLK_W-1:0] single_off;
    logic [BLK_W-1:0] double_off;

    assign in_ready   = !q_full;
    assign push       = in_valid && !q_full;
    assign block      = byte_offset[OFFSET_W-1:SB_SHIFT];
    assign single_off = block - DIRECT_END;
    assign double_off = block - SINGLE_END;

    always_comb
    begin
        push_cmd              = '0;
        push_cmd.ins          = (req_type == REQ_INSERT);
        push_cmd.data         = data_sector;
        push_cmd.spare_first  = spare_first;
        push_cmd.spare_second = spare_second;
        // A count of three offers only the two spares there are.
        push_cmd.spare0_ok    = (spare_count != 2'd0) && (spare_first != NP);
        push_cmd.spare1_ok    = spare_count[1] && (spare_second != NP);
        priority if (req_type == REQ_CLEAR)
        begin
            push_cmd.kind = K_CLEAR;
        end
        else if ((req_type != REQ_LOOKUP) && (req_type != REQ_INSERT))
        begin
            push_cmd.kind = K_NOP;
        end
        else if (block >= BLOCK_MAX)
        begin
            push_cmd.kind = K_BEYOND;
        end
        else if (block < DIRECT_END)
        begin
            push_cmd.kind = K_DIRECT;
            push_cmd.idx  = LEAF_W'(block);
        end
        else if (block < SINGLE_END)
        begin
            push_cmd.kind = K_SINGLE;
            push_cmd.idx  = LEAF_W'(single_off);
        end
        else
        begin
            push_cmd.kind = K_DOUBLE;
            push_cmd.idx  = LEAF_W'(double_off);
        end
    end

endmodule

### rtl/imb_queue.sv
`timescale 1ns / 1ps

module imb_queue
    import imb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t head
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QDEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);

    cmd_t             slot_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### rtl/imb_back.sv
`timescale 1ns / 1ps

module imb_back
    import imb_pkg::*;
#(
    parameter int DIRECT_COUNT = DIRECT_COUNT_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  cmd_t                head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SECTOR_W-1:0] sector,
    output logic [1:0]          status,
    output logic [1:0]          spares_used
);

    localparam int TOP_DEPTH = DIRECT_COUNT + 2;
    localparam int DIR_W     = $clog2(TOP_DEPTH);
    localparam logic [DIR_W-1:0] SINGLE_SLOT = DIR_W'(DIRECT_COUNT);
    localparam logic [DIR_W-1:0] DOUBLE_SLOT = DIR_W'(DIRECT_COUNT + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SREAD = 2'd1;
    localparam logic [1:0] ST_TOP   = 2'd2;
    localparam logic [1:0] ST_LEAF  = 2'd3;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    cmd_t                cur_reg;
    cmd_t                cur_next;
    logic                taken_reg;
    logic                taken_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [SECTOR_W-1:0] out_sector_reg;
    logic [1:0]          out_status_reg;
    logic [1:0]          out_used_reg;

    logic [SECTOR_W-1:0] direct_reg [TOP_DEPTH];
    logic [EPI-1:0]      single_vld_reg;
    logic [EPI-1:0]      single_vld_next;
    logic [EPI-1:0]      top_vld_reg;
    logic [EPI-1:0]      top_vld_next;

    logic [SECTOR_W-1:0] single_mem [EPI];
    logic [SECTOR_W-1:0] top_mem [EPI];
    logic [SECTOR_W-1:0] leaf_mem [LEAF_COUNT];
    logic [EPI-1:0]      row_mem [EPI];
    logic [SECTOR_W-1:0] single_rd_reg;
    logic [SECTOR_W-1:0] top_rd_reg;
    logic [SECTOR_W-1:0] leaf_rd_reg;
    logic [EPI-1:0]      row_rd_reg;

    cmd_t                w;
    logic [EPI_W-1:0]    lo;
    logic [EPI_W-1:0]    hi;
    logic [DIR_W-1:0]    didx;
    logic [EPI-1:0]      lo_mask;
    logic                out_free;

    logic                fin;
    logic [SECTOR_W-1:0] fin_sector;
    logic [1:0]          fin_status;
    logic [1:0]          fin_used;
    logic                dir_clear;
    logic                dir_we;
    logic [DIR_W-1:0]    dir_waddr;
    logic [SECTOR_W-1:0] dir_wdata;
    logic                single_we;
    logic                top_we;
    logic [SECTOR_W-1:0] top_wdata;
    logic                leaf_we;
    logic                row_we;
    logic [EPI-1:0]      row_wdata;
    logic                slot_present;
    logic                top_present;
    logic                spare_ok;
    logic [SECTOR_W-1:0] spare_val;
    logic [SECTOR_W-1:0] look;

    // While idle the memories are addressed from the queue head, otherwise from the
    // item in progress.
    assign w        = (state_reg == ST_IDLE) ? head : cur_reg;
    assign lo       = w.idx[EPI_W-1:0];
    assign hi       = w.idx[LEAF_W-1:EPI_W];
    assign didx     = w.idx[DIR_W-1:0];
    assign lo_mask  = EPI'(1) << lo;
    assign out_free = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign sector      = out_sector_reg;
    assign status      = out_status_reg;
    assign spares_used = out_used_reg;

    always_comb
    begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        taken_next   = taken_reg;
        pop          = 1'b0;
        fin          = 1'b0;
        fin_sector   = NP;
        fin_status   = STAT_OK;
        fin_used     = 2'd0;
        dir_clear    = 1'b0;
        dir_we       = 1'b0;
        dir_waddr    = didx;
        dir_wdata    = w.data;
        single_we    = 1'b0;
        top_we       = 1'b0;
        top_wdata    = w.spare_first;
        leaf_we      = 1'b0;
        row_we       = 1'b0;
        row_wdata    = lo_mask;
        slot_present = 1'b0;
        top_present  = top_vld_reg[hi] && (top_rd_reg != NP);
        spare_ok     = taken_reg ? w.spare1_ok : w.spare0_ok;
        spare_val    = taken_reg ? w.spare_second : w.spare_first;
        look         = NP;
        single_vld_next = single_vld_reg;
        top_vld_next    = top_vld_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    pop        = 1'b1;
                    cur_next   = head;
                    taken_next = 1'b0;
                    unique case (head.kind)
                        K_CLEAR:
                        begin
                            dir_clear = 1'b1;
                            fin       = 1'b1;
                        end
                        K_BEYOND:
                        begin
                            fin        = 1'b1;
                            fin_status = STAT_BEYOND;
                        end
                        K_DIRECT:
                        begin
                            fin = 1'b1;
                            if (head.ins)
                            begin
                                dir_we     = 1'b1;
                                fin_sector = head.data;
                            end
                            else
                            begin
                                fin_sector = direct_reg[didx];
                                fin_status = (direct_reg[didx] == NP) ? STAT_ABSENT : STAT_OK;
                            end
                        end
                        K_SINGLE:
                        begin
                            slot_present = (direct_reg[SINGLE_SLOT] != NP);
                            if (!slot_present && !head.ins)
                            begin
                                fin        = 1'b1;
                                fin_status = STAT_ABSENT;
                            end
                            else if (!slot_present && !head.spare0_ok)
                            begin
                                fin        = 1'b1;
                                fin_status = STAT_NOSPARE;
                            end
                            else if (head.ins)
                            begin
                                if (!slot_present)
                                begin
                                    dir_we          = 1'b1;
                                    dir_waddr       = SINGLE_SLOT;
                                    dir_wdata       = head.spare_first;
                                    single_vld_next = '0;
                                    fin_used        = 2'd1;
                                end
                                single_we           = 1'b1;
                                single_vld_next[lo] = 1'b1;
                                fin                 = 1'b1;
                                fin_sector          = head.data;
                            end
                            else
                            begin
                                state_next = ST_SREAD;
                            end
                        end
                        K_DOUBLE:
                        begin
                            slot_present = (direct_reg[DOUBLE_SLOT] != NP);
                            if (!slot_present && !head.ins)
                            begin
                                fin        = 1'b1;
                                fin_status = STAT_ABSENT;
                            end
                            else if (!slot_present && !head.spare0_ok)
                            begin
                                fin        = 1'b1;
                                fin_status = STAT_NOSPARE;
                            end
                            else
                            begin
                                if (!slot_present)
                                begin
                                    // A fresh top block: every entry below it reads absent.
                                    dir_we       = 1'b1;
                                    dir_waddr    = DOUBLE_SLOT;
                                    dir_wdata    = head.spare_first;
                                    top_vld_next = '0;
                                    taken_next   = 1'b1;
                                end
                                state_next = ST_TOP;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            ST_SREAD:
            begin
                look       = single_vld_reg[lo] ? single_rd_reg : NP;
                fin        = 1'b1;
                fin_sector = look;
                fin_status = (look == NP) ? STAT_ABSENT : STAT_OK;
            end
            ST_TOP:
            begin
                if (top_present)
                begin
                    state_next = ST_LEAF;
                end
                else if (!cur_reg.ins)
                begin
                    fin        = 1'b1;
                    fin_status = STAT_ABSENT;
                end
                else if (!spare_ok)
                begin
                    fin        = 1'b1;
                    fin_status = STAT_NOSPARE;
                    fin_used   = {1'b0, taken_reg};
                end
                else
                begin
                    // New leaf block: its valid row holds only the entry written now.
                    top_we           = 1'b1;
                    top_wdata        = spare_val;
                    top_vld_next[hi] = 1'b1;
                    leaf_we          = 1'b1;
                    row_we           = 1'b1;
                    row_wdata        = lo_mask;
                    fin              = 1'b1;
                    fin_sector       = cur_reg.data;
                    fin_used         = taken_reg ? 2'd2 : 2'd1;
                end
            end
            ST_LEAF:
            begin
                fin = 1'b1;
                if (cur_reg.ins)
                begin
                    leaf_we    = 1'b1;
                    row_we     = 1'b1;
                    row_wdata  = row_rd_reg | lo_mask;
                    fin_sector = cur_reg.data;
                    fin_used   = {1'b0, taken_reg};
                end
                else
                begin
                    look       = row_rd_reg[lo] ? leaf_rd_reg : NP;
                    fin_sector = look;
                    fin_status = (look == NP) ? STAT_ABSENT : STAT_OK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (fin)
        begin
            state_next = ST_IDLE;
        end

        if (cur_reg.ins && fin_status != STAT_OK)
        begin
            fin_sector = NP;
        end
        if (fin)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            taken_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            single_vld_reg <= '0;
            top_vld_reg    <= '0;
            for (int i = 0; i < TOP_DEPTH; i++)
            begin
                direct_reg[i] <= NP;
            end
        end
        else
        begin
            state_reg      <= state_next;
            taken_reg      <= taken_next;
            out_valid_reg  <= out_valid_next;
            single_vld_reg <= single_vld_next;
            top_vld_reg    <= top_vld_next;
            if (dir_clear)
            begin
                for (int i = 0; i < TOP_DEPTH; i++)
                begin
                    direct_reg[i] <= NP;
                end
            end
            else if (dir_we)
            begin
                direct_reg[dir_waddr] <= dir_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (fin)
        begin
            out_sector_reg <= fin_sector;
            out_status_reg <= fin_status;
            out_used_reg   <= fin_used;
        end
    end

    always_ff @(posedge clk)
    begin
        if (single_we)
        begin
            single_mem[lo] <= w.data;
        end
        single_rd_reg <= single_mem[lo];
    end

    always_ff @(posedge clk)
    begin
        if (top_we)
        begin
            top_mem[hi] <= top_wdata;
        end
        top_rd_reg <= top_mem[hi];
    end

    always_ff @(posedge clk)
    begin
        if (leaf_we)
        begin
            leaf_mem[w.idx] <= w.data;
        end
        leaf_rd_reg <= leaf_mem[w.idx];
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[hi] <= row_wdata;
        end
        row_rd_reg <= row_mem[hi];
    end

endmodule

### tb/inode_block_map_translate_tb.sv
`timescale 1ns / 1ps

module inode_block_map_translate_tb;

    import imb_pkg::*;

    localparam int          RESET_CYCLES = 12;
    localparam int          RANDOM_WORDS = 800;
    localparam int          CALM_WORDS   = 80;
    localparam int          HOLD_CYCLES  = 250;
    localparam int          HOLD_AT      = 300;
    localparam int          STALL_LIMIT  = 3000;
    localparam int          DRAIN_CYCLES = 20;
    localparam int unsigned DIRECT_N     = DIRECT_COUNT_DEF;
    localparam int unsigned SINGLE_SLOT  = DIRECT_N;
    localparam int unsigned DOUBLE_SLOT  = DIRECT_N + 1;
    localparam int unsigned SINGLE_END   = DIRECT_N + EPI;
    localparam int unsigned BLOCK_LIMIT  = SINGLE_END + EPI * EPI;
    localparam logic [1:0]  REQ_UNKNOWN  = 2'd3;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [OFFSET_W-1:0] byte_offset;
        logic [SECTOR_W-1:0] data_sector;
        logic [1:0]          spare_count;
        logic [SECTOR_W-1:0] spare_first;
        logic [SECTOR_W-1:0] spare_second;
    } map_req_t;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic [1:0]          status;
        logic [1:0]          spares_used;
    } map_res_t;

    typedef struct {
        map_req_t w;
        bit       typed;
        map_res_t want;
    } plan_row_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                in_valid     = 1'b0;
    logic                in_ready;
    logic [1:0]          req_type     = '0;
    logic [OFFSET_W-1:0] byte_offset  = '0;
    logic [SECTOR_W-1:0] data_sector  = '0;
    logic [1:0]          spare_count  = '0;
    logic [SECTOR_W-1:0] spare_first  = '0;
    logic [SECTOR_W-1:0] spare_second = '0;
    logic                out_valid;
    logic                out_ready    = 1'b0;
    logic [SECTOR_W-1:0] sector;
    logic [1:0]          status;
    logic [1:0]          spares_used;

    // Shadow copy of the block map.
    logic [SECTOR_W-1:0] top_table [DIRECT_N+2];
    logic [SECTOR_W-1:0] single_ent [EPI];
    logic [SECTOR_W-1:0] dtop_ent [EPI];
    logic [SECTOR_W-1:0] leaf_ent [LEAF_COUNT];
    bit                  single_ok [EPI];
    bit                  dtop_ok [EPI];
    bit                  leaf_ok [LEAF_COUNT];

    plan_row_t   stim_plan [$];
    map_res_t    awaited_results [$];
    int unsigned words_sent = 0;
    int unsigned mismatches = 0;
    int unsigned send_odds  = 0;
    bit          calm       = 1'b0;
    bit          hold_go    = 1'b0;
    int unsigned quiet_cycles = 0;

    inode_block_map_translate dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .byte_offset  (byte_offset),
        .data_sector  (data_sector),
        .spare_count  (spare_count),
        .spare_first  (spare_first),
        .spare_second (spare_second),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sector       (sector),
        .status       (status),
        .spares_used  (spares_used)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [OFFSET_W-1:0] at_block(input int unsigned b);
        return OFFSET_W'(b << SB_SHIFT);
    endfunction

    function automatic bit grab_spare(input map_req_t w, input int unsigned avail,
                                      inout int unsigned taken, output logic [SECTOR_W-1:0] s);
        logic [SECTOR_W-1:0] v;
        s = NP;
        if (taken >= avail)
            return 1'b0;
        v = (taken == 0) ? w.spare_first : w.spare_second;
        if (v == NP)
            return 1'b0;
        taken++;
        s = v;
        return 1'b1;
    endfunction

    // Applies one request word to the shadow map and returns the result word it earns.
    function automatic map_res_t translate(input map_req_t w);
        map_res_t            r;
        int unsigned         blk;
        int unsigned         k;
        int unsigned         d;
        int unsigned         hi;
        int unsigned         avail;
        int unsigned         taken;
        logic [SECTOR_W-1:0] s;
        bit                  ins;
        bit                  have;
        r.sector      = NP;
        r.status      = STAT_OK;
        avail         = (w.spare_count > 2) ? 2 : w.spare_count;
        taken         = 0;
        blk           = w.byte_offset >> SB_SHIFT;
        ins           = (w.req_type == REQ_INSERT);
        if (w.req_type == REQ_CLEAR)
        begin
            foreach (top_table[i])
                top_table[i] = NP;
        end
        else if (w.req_type == REQ_LOOKUP || w.req_type == REQ_INSERT)
        begin
            if (blk >= BLOCK_LIMIT)
            begin
                r.status = STAT_BEYOND;
            end
            else if (blk < DIRECT_N)
            begin
                if (ins)
                begin
                    top_table[blk] = w.data_sector;
                    r.sector       = w.data_sector;
                end
                else
                begin
                    r.sector = top_table[blk];
                end
            end
            else if (blk < SINGLE_END)
            begin
                k    = blk - DIRECT_N;
                have = 1'b1;
                if (top_table[SINGLE_SLOT] == NP)
                begin
                    if (!ins)
                    begin
                        have = 1'b0;
                    end
                    else if (!grab_spare(w, avail, taken, s))
                    begin
                        have     = 1'b0;
                        r.status = STAT_NOSPARE;
                    end
                    else
                    begin
                        top_table[SINGLE_SLOT] = s;
                        foreach (single_ok[i])
                            single_ok[i] = 1'b0;
                    end
                end
                if (have)
                begin
                    if (ins)
                    begin
                        single_ent[k] = w.data_sector;
                        single_ok[k]  = 1'b1;
                        r.sector      = w.data_sector;
                    end
                    else if (single_ok[k])
                    begin
                        r.sector = single_ent[k];
                    end
                end
            end
            else
            begin
                d    = blk - SINGLE_END;
                hi   = d / EPI;
                have = 1'b1;
                if (top_table[DOUBLE_SLOT] == NP)
                begin
                    if (!ins)
                    begin
                        have = 1'b0;
                    end
                    else if (!grab_spare(w, avail, taken, s))
                    begin
                        have     = 1'b0;
                        r.status = STAT_NOSPARE;
                    end
                    else
                    begin
                        top_table[DOUBLE_SLOT] = s;
                        foreach (dtop_ok[i])
                            dtop_ok[i] = 1'b0;
                    end
                end
                if (have && (!dtop_ok[hi] || dtop_ent[hi] == NP))
                begin
                    if (!ins)
                    begin
                        have = 1'b0;
                    end
                    else if (!grab_spare(w, avail, taken, s))
                    begin
                        have     = 1'b0;
                        r.status = STAT_NOSPARE;
                    end
                    else
                    begin
                        dtop_ent[hi] = s;
                        dtop_ok[hi]  = 1'b1;
                        for (int j = 0; j < EPI; j++)
                            leaf_ok[hi * EPI + j] = 1'b0;
                    end
                end
                if (have)
                begin
                    if (ins)
                    begin
                        leaf_ent[d] = w.data_sector;
                        leaf_ok[d]  = 1'b1;
                        r.sector    = w.data_sector;
                    end
                    else if (leaf_ok[d])
                    begin
                        r.sector = leaf_ent[d];
                    end
                end
            end
            if (!ins && r.status == STAT_OK && r.sector == NP)
                r.status = STAT_ABSENT;
            if (ins && r.status != STAT_OK)
                r.sector = NP;
        end
        r.spares_used = taken[1:0];
        return r;
    endfunction

    function automatic void plan(input logic [1:0] t, input logic [OFFSET_W-1:0] off,
                                 input logic [SECTOR_W-1:0] dat, input logic [1:0] cnt,
                                 input logic [SECTOR_W-1:0] s0, input logic [SECTOR_W-1:0] s1,
                                 input bit typed, input logic [SECTOR_W-1:0] sec,
                                 input logic [1:0] st, input logic [1:0] sp);
        plan_row_t row;
        row.w     = '{t, off, dat, cnt, s0, s1};
        row.typed = typed;
        row.want  = '{sec, st, sp};
        stim_plan.push_back(row);
    endfunction

    task automatic offer(input map_req_t w, input bit typed, input map_res_t want);
        map_res_t    got;
        int unsigned gap;
        if (words_sent % 40 == 0)
        begin
            case ($urandom_range(0, 2))
                0:       send_odds = 0;
                1:       send_odds = 10;
                default: send_odds = 40;
            endcase
        end
        if (!calm && $urandom_range(0, 99) < send_odds)
        begin
            gap = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= w.req_type;
        byte_offset  <= w.byte_offset;
        data_sector  <= w.data_sector;
        spare_count  <= w.spare_count;
        spare_first  <= w.spare_first;
        spare_second <= w.spare_second;
        do
            @(posedge clk);
        while (!in_ready);
        got = translate(w);
        awaited_results.push_back(typed ? want : got);
        words_sent++;
        if (words_sent == HOLD_AT)
            hold_go = 1'b1;
        if (words_sent + CALM_WORDS >= stim_plan.size() + RANDOM_WORDS)
            calm = 1'b1;
    endtask

    task automatic compare_field(input string name, input logic [SECTOR_W-1:0] want,
                                 input logic [SECTOR_W-1:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    initial
    begin : request_side
        map_req_t    w;
        map_res_t    none;
        int unsigned r;
        int unsigned blk;
        none = '0;

        // Directed words: extremes, every request type and the corner cases of the map.
        plan(REQ_LOOKUP, '0, '0, 2'd0, '0, '0, 1, NP, STAT_ABSENT, 2'd0);
        plan(REQ_LOOKUP, '1, 32'hFFFF_FFFE, 2'd3, '0, '0, 1, NP, STAT_BEYOND, 2'd0);
        plan(REQ_INSERT, '1, 32'h0000_0055, 2'd2, 32'd5, 32'd6, 1, NP, STAT_BEYOND, 2'd0);
        plan(REQ_INSERT, at_block(BLOCK_LIMIT), 32'd9, 2'd2, 32'd5, 32'd6, 1,
             NP, STAT_BEYOND, 2'd0);
        plan(REQ_INSERT, '0, '0, 2'd0, '0, '0, 1, '0, STAT_OK, 2'd0);
        plan(REQ_LOOKUP, at_block(0) | 31'd511, '0, 2'd0, '0, '0, 0, NP, STAT_OK, 2'd0);
        plan(REQ_INSERT, at_block(DIRECT_N - 1) | 31'd511, 32'hFFFF_FFFE, 2'd1, '0, '0, 1,
             32'hFFFF_FFFE, STAT_OK, 2'd0);
        plan(REQ_INSERT, at_block(SINGLE_END - EPI), 32'd77, 2'd0, 32'd7, 32'd8, 1,
             NP, STAT_NOSPARE, 2'd0);
        plan(REQ_INSERT, at_block(SINGLE_END - EPI), 32'd77, 2'd1, NP, 32'd8, 1,
             NP, STAT_NOSPARE, 2'd0);
        plan(REQ_LOOKUP, at_block(SINGLE_END - EPI), '0, 2'd0, '0, '0, 1, NP, STAT_ABSENT, 2'd0);
        plan(REQ_INSERT, at_block(SINGLE_END - EPI), 32'h1234, 2'd3, '0, 32'hFFFF_FFFE, 1,
             32'h1234, STAT_OK, 2'd1);
        plan(REQ_LOOKUP, at_block(SINGLE_END - EPI + 1), '0, 2'd0, '0, '0, 0, NP, STAT_OK, 2'd0);
        plan(REQ_LOOKUP, at_block(SINGLE_END - EPI), '0, 2'd0, '0, '0, 0, NP, STAT_OK, 2'd0);
        // Storing the not-present value makes the entry read as absent.
        plan(REQ_INSERT, at_block(SINGLE_END - 1), NP, 2'd2, 32'd3, 32'd4, 0,
             NP, STAT_OK, 2'd0);
        plan(REQ_LOOKUP, at_block(SINGLE_END - 1), '0, 2'd0, '0, '0, 0, NP, STAT_OK, 2'd0);
        // One spare only: the top block is kept although the leaf cannot be made.
        plan(REQ_INSERT, at_block(SINGLE_END), 32'hABCD, 2'd1, 32'd200, 32'd201, 1,
             NP, STAT_NOSPARE, 2'd1);
        plan(REQ_INSERT, at_block(SINGLE_END), 32'hABCD, 2'd2, 32'd300, 32'd301, 0,
             NP, STAT_OK, 2'd0);
        plan(REQ_INSERT, at_block(BLOCK_LIMIT - 1) | 31'd511, 32'd42, 2'd2, NP, 32'd9, 0,
             NP, STAT_OK, 2'd0);
        plan(REQ_LOOKUP, at_block(BLOCK_LIMIT - 1), '0, 2'd0, '0, '0, 0, NP, STAT_OK, 2'd0);
        plan(REQ_CLEAR, '1, '1, 2'd3, '1, '1, 1, NP, STAT_OK, 2'd0);
        plan(REQ_LOOKUP, '0, '0, 2'd0, '0, '0, 0, NP, STAT_OK, 2'd0);
        plan(REQ_INSERT, at_block(SINGLE_END + 130), 32'h5A5A, 2'd2, 32'd500, 32'd501, 0,
             NP, STAT_OK, 2'd0);
        plan(REQ_LOOKUP, at_block(SINGLE_END), '0, 2'd0, '0, '0, 0, NP, STAT_OK, 2'd0);
        plan(REQ_UNKNOWN, at_block(3), 32'd1, 2'd2, 32'd1, 32'd2, 1, NP, STAT_OK, 2'd0);
        plan(REQ_LOOKUP, at_block(SINGLE_END + 130), '0, 2'd0, '0, '0, 0, NP, STAT_OK, 2'd0);

        foreach (top_table[i])
            top_table[i] = NP;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_plan[i])
            offer(stim_plan[i].w, stim_plan[i].typed, stim_plan[i].want);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 44)
                w.req_type = REQ_LOOKUP;
            else if (r < 92)
                w.req_type = REQ_INSERT;
            else if (r < 96)
                w.req_type = REQ_CLEAR;
            else
                w.req_type = REQ_UNKNOWN;

            r = $urandom_range(0, 99);
            if (r < 5)
            begin
                w.byte_offset = OFFSET_W'($urandom());
            end
            else
            begin
                if (r < 10)
                    blk = BLOCK_LIMIT + $urandom_range(0, 4000);
                else if (r < 35)
                    blk = $urandom_range(0, DIRECT_N - 1);
                else if (r < 60)
                    blk = $urandom_range(DIRECT_N, SINGLE_END - 1);
                else if (r < 85)
                    blk = SINGLE_END + $urandom_range(0, 3) * EPI + $urandom_range(0, 15);
                else
                    blk = SINGLE_END + $urandom_range(0, EPI * EPI - 1);
                w.byte_offset = at_block(blk) | OFFSET_W'($urandom_range(0, SECTOR_BYTES - 1));
            end

            w.data_sector  = ($urandom_range(0, 15) == 0) ? NP : $urandom();
            w.spare_count  = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : 2'd2;
            w.spare_first  = ($urandom_range(0, 9) == 0) ? NP : $urandom();
            w.spare_second = ($urandom_range(0, 9) == 0) ? NP : $urandom();
            offer(w, 1'b0, none);
        end
        in_valid <= 1'b0;

        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("inode_block_map_translate_tb passed");
        else
            $display("inode_block_map_translate_tb failed");
        $finish;
    end

    initial
    begin : result_side
        int unsigned ticks;
        int unsigned odds;
        int unsigned gap;
        bit          hold_done;
        ticks     = 0;
        odds      = 0;
        hold_done = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (ticks % 128 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       odds = 0;
                    1:       odds = 8;
                    default: odds = 25;
                endcase
            end
            ticks++;
            if (hold_go && !hold_done)
            begin
                // Long hold-off so that the queue fills and the request side backs up.
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 99) < odds)
            begin
                gap = $urandom_range(1, 17);
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        map_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: result word with nothing expected, got sector %h status %h used %h",
                         $time, sector, status, spares_used);
            end
            else
            begin
                want = awaited_results.pop_front();
                compare_field("sector", want.sector, sector);
                compare_field("status", SECTOR_W'(want.status), SECTOR_W'(status));
                compare_field("spares_used", SECTOR_W'(want.spares_used), SECTOR_W'(spares_used));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
            $display("inode_block_map_translate_tb failed");
            $finish;
        end
    end

endmodule
